// File: rtl/ibsb_pkg.sv
// shared constants, types and register codes of the ibus to sbus converter
package ibsb_pkg;

   // frame geometry
   localparam int FRAME_BYTES = 32;
   localparam int CHANNELS    = 14;
   localparam int SBUS_BYTES  = 23;
   localparam int SBUS_CHANS  = 16;
   localparam int CHAN_BITS   = 11;

   localparam int ADDR_W    = $clog2(FRAME_BYTES);
   localparam int CHAN_W    = $clog2(SBUS_CHANS);
   localparam int IDX_W     = 5;
   localparam int ACC_W     = CHAN_BITS + 7;
   localparam int ACC_CNT_W = 5;
   localparam int PROD_W    = 30;

   // byte positions inside the ibus frame
   localparam logic [ADDR_W-1:0] CMD_POS    = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] SUM_LO_POS = ADDR_W'(FRAME_BYTES - 2);
   localparam logic [ADDR_W-1:0] LAST_POS   = ADDR_W'(FRAME_BYTES - 1);

   localparam logic [CHAN_W-1:0] LAST_CHAN  = CHAN_W'(SBUS_CHANS - 1);
   localparam logic [CHAN_W-1:0] USED_CHANS = CHAN_W'(CHANNELS);

   localparam logic [7:0]  START_BYTE = 8'h20;
   localparam logic [7:0]  CMD_BYTE   = 8'h40;
   localparam logic [15:0] SUM_INIT   = 16'hFFFF;
   localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(32768);
   localparam logic [CHAN_BITS-1:0] SBUS_MAX = '1;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CLAMP_LOW   = 3'd0,
      REG_CLAMP_HIGH  = 3'd1,
      REG_PWM_MIN     = 3'd2,
      REG_SBUS_MIN    = 3'd3,
      REG_SCALE_RATIO = 3'd4
   } ibsb_reg_type;

   localparam logic [11:0] CLAMP_LOW_RST   = 12'd885;
   localparam logic [11:0] CLAMP_HIGH_RST  = 12'd2160;
   localparam logic [11:0] PWM_MIN_RST     = 12'd988;
   localparam logic [10:0] SBUS_MIN_RST    = 11'd172;
   localparam logic [17:0] SCALE_RATIO_RST = 18'd104896;

   typedef struct packed {
      logic [11:0] clamp_low;
      logic [11:0] clamp_high;
      logic [11:0] pwm_min;
      logic [10:0] sbus_min;
      logic [17:0] scale_ratio;
   } ibsb_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic              take;
      logic              rd_sel_hi;
      logic              lo_en;
      logic              clamp_en;
      logic              mul_en;
      logic              append_en;
      logic              emit_en;
      logic              tail_en;
      logic [CHAN_W-1:0] chan;
   } ibsb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic frame_good;
      logic acc_ready;
      logic out_free;
   } ibsb_status_type;

endpackage

// File: rtl/ibsb_if.sv
// valid/ready channel interfaces for received bytes and sbus output words
interface ibsb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       after_gap;

   modport source (output valid, rx_byte, after_gap, input ready);
   modport sink   (input valid, rx_byte, after_gap, output ready);
endinterface

interface ibsb_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [7:0]                 out_byte;
   logic [ibsb_pkg::IDX_W-1:0] byte_index;
   logic                       last;

   modport source (output valid, out_byte, byte_index, last, input ready);
   modport sink   (input valid, out_byte, byte_index, last, output ready);
endinterface

// File: rtl/ibsb_ram.sv
// generic single write port ram with registered read
module ibsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/ibsb_csr.sv
// configuration registers of the converter
module ibsb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [ibsb_pkg::CSR_INDEX_W-1:0]   index,
   input  logic [ibsb_pkg::CSR_DATA_W-1:0]    wr_data,
   output ibsb_pkg::ibsb_cfg_type             cfg
);
   import ibsb_pkg::*;

   ibsb_cfg_type cfg_ff;
   ibsb_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (ibsb_reg_type'(index))
            REG_CLAMP_LOW:   cfg_in.clamp_low   = wr_data[11:0];
            REG_CLAMP_HIGH:  cfg_in.clamp_high  = wr_data[11:0];
            REG_PWM_MIN:     cfg_in.pwm_min     = wr_data[11:0];
            REG_SBUS_MIN:    cfg_in.sbus_min    = wr_data[10:0];
            REG_SCALE_RATIO: cfg_in.scale_ratio = wr_data[17:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clamp_low   <= CLAMP_LOW_RST;
         cfg_ff.clamp_high  <= CLAMP_HIGH_RST;
         cfg_ff.pwm_min     <= PWM_MIN_RST;
         cfg_ff.sbus_min    <= SBUS_MIN_RST;
         cfg_ff.scale_ratio <= SCALE_RATIO_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/ibsb_ctrl.sv
// sequencing state machine: receive, per channel convert, pack and emit
module ibsb_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ibsb_pkg::ibsb_status_type  status,
   output ibsb_pkg::ibsb_cmd_type     cmd
);
   import ibsb_pkg::*;

   typedef enum logic [7:0] {
      S_RECV  = 8'b0000_0001,
      S_RD_LO = 8'b0000_0010,
      S_RD_HI = 8'b0000_0100,
      S_CLAMP = 8'b0000_1000,
      S_MUL   = 8'b0001_0000,
      S_SCALE = 8'b0010_0000,
      S_EMIT  = 8'b0100_0000,
      S_TAIL  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      cmd           = '0;
      cmd.chan      = chan_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         S_RECV: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (status.frame_good) begin
               chan_in  = '0;
               state_in = S_RD_LO;
            end
         end
         S_RD_LO: begin
            state_in = S_RD_HI;
         end
         S_RD_HI: begin
            cmd.rd_sel_hi = 1'b1;
            cmd.lo_en     = 1'b1;
            state_in      = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp_en = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_SCALE;
         end
         S_SCALE: begin
            cmd.append_en = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (status.acc_ready) begin
               cmd.emit_en = status.out_free;
            end else if (chan_ff == LAST_CHAN) begin
               state_in = S_TAIL;
            end else begin
               chan_in = chan_ff + CHAN_W'(1);
               // unused channels skip the reads and pack as zero
               state_in = (chan_in < USED_CHANS) ? S_RD_LO : S_SCALE;
            end
         end
         S_TAIL: begin
            cmd.tail_en = status.out_free;
            if (status.out_free) begin
               state_in = S_RECV;
            end
         end
         default: begin
            state_in = S_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RECV;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

// File: rtl/ibsb_dpath.sv
// frame capture, checksum, channel conversion, bit packing and output word register
module ibsb_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  ibsb_pkg::ibsb_cmd_type      cmd,
   output ibsb_pkg::ibsb_status_type   status,
   input  ibsb_pkg::ibsb_cfg_type      cfg,
   input  logic [7:0]                  rx_byte,
   input  logic                        after_gap,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  out_byte,
   output logic [ibsb_pkg::IDX_W-1:0]  byte_index,
   output logic                        last
);
   import ibsb_pkg::*;

   // receive side
   logic              in_frame_ff, in_frame_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [15:0]       sum_ff, sum_in;
   logic              cmd_ok_ff, cmd_ok_in;
   logic [7:0]        sum_lo_ff, sum_lo_in;
   logic              gap_frame;
   logic [ADDR_W-1:0] pos;
   logic [15:0]       run_sum;
   logic              frame_good;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   // conversion
   logic [7:0]           lo_ff;
   logic [15:0]          p, p_lo, p_hi;
   logic [11:0]          pc, d;
   logic [11:0]          d_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [PROD_W:0]      rnd;
   logic [15:0]          tot;
   logic [CHAN_BITS-1:0] chan_val;

   // packing and output
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_CNT_W-1:0] acc_cnt_ff, acc_cnt_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_byte_ff;
   logic [IDX_W-1:0]     byte_index_ff;
   logic                 last_ff;
   logic                 load;

   always_comb begin
      in_frame_in = in_frame_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      cmd_ok_in   = cmd_ok_ff;
      sum_lo_in   = sum_lo_ff;
      wr_en       = 1'b0;
      frame_good  = 1'b0;
      gap_frame   = in_frame_ff;
      pos         = cnt_ff;
      run_sum     = sum_ff;
      if (cmd.take) begin
         if (after_gap) begin
            gap_frame = (rx_byte == START_BYTE);
            pos       = '0;
            if (rx_byte == START_BYTE) begin
               run_sum = SUM_INIT;
            end
         end
         sum_in = run_sum;
         if (gap_frame) begin
            wr_en = 1'b1;
            if (pos < SUM_LO_POS) begin
               sum_in = run_sum - {8'd0, rx_byte};
            end
            if (pos == CMD_POS) begin
               cmd_ok_in = (rx_byte == CMD_BYTE);
            end
            if (pos == SUM_LO_POS) begin
               sum_lo_in = rx_byte;
            end
            if (pos == LAST_POS) begin
               in_frame_in = 1'b0;
               cnt_in      = '0;
               frame_good  = cmd_ok_ff && (run_sum == {rx_byte, sum_lo_ff});
            end else begin
               in_frame_in = 1'b1;
               cnt_in      = pos + ADDR_W'(1);
            end
         end else begin
            in_frame_in = 1'b0;
            cnt_in      = '0;
         end
      end
   end

   // channel i sits at bytes 2+2i (low) and 3+2i (high)
   assign rd_addr = ADDR_W'({cmd.chan, cmd.rd_sel_hi}) + ADDR_W'(2);

   ibsb_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos),
      .wr_data (rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // clamp low first, then high, so clamp_high wins when the limits cross
   always_comb begin
      p    = {rd_data, lo_ff};
      p_lo = (p < 16'(cfg.clamp_low)) ? 16'(cfg.clamp_low) : p;
      p_hi = (p_lo > 16'(cfg.clamp_high)) ? 16'(cfg.clamp_high) : p_lo;
      pc   = p_hi[11:0];
      d    = (pc >= cfg.pwm_min) ? (pc - cfg.pwm_min) : '0;
   end

   // round half up, add offset, saturate to 11 bits; unused channels give zero
   always_comb begin
      rnd = {1'b0, prod_ff} + RND_HALF;
      tot = {1'b0, rnd[PROD_W:16]} + 16'(cfg.sbus_min);
      if (cmd.chan >= USED_CHANS) begin
         chan_val = '0;
      end else if (tot > 16'(SBUS_MAX)) begin
         chan_val = SBUS_MAX;
      end else begin
         chan_val = tot[CHAN_BITS-1:0];
      end
   end

   assign load = cmd.emit_en | cmd.tail_en;

   always_comb begin
      acc_in     = acc_ff;
      acc_cnt_in = acc_cnt_ff;
      idx_in     = idx_ff;
      if (frame_good) begin
         acc_in     = '0;
         acc_cnt_in = '0;
         idx_in     = '0;
      end else if (cmd.append_en) begin
         acc_in     = acc_ff | (ACC_W'(chan_val) << acc_cnt_ff);
         acc_cnt_in = acc_cnt_ff + ACC_CNT_W'(CHAN_BITS);
      end else if (cmd.emit_en) begin
         acc_in     = acc_ff >> 8;
         acc_cnt_in = acc_cnt_ff - ACC_CNT_W'(8);
      end
      if (load) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         cnt_ff       <= '0;
         sum_ff       <= SUM_INIT;
         acc_cnt_ff   <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         acc_cnt_ff   <= acc_cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ok_ff <= cmd_ok_in;
      sum_lo_ff <= sum_lo_in;
      acc_ff    <= acc_in;
      if (cmd.lo_en) begin
         lo_ff <= rd_data;
      end
      if (cmd.clamp_en) begin
         d_ff <= d;
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(d_ff) * PROD_W'(cfg.scale_ratio);
      end
      if (load) begin
         out_byte_ff   <= cmd.tail_en ? 8'd0 : acc_ff[7:0];
         byte_index_ff <= idx_ff;
         last_ff       <= cmd.tail_en;
      end
   end

   assign status.frame_good = frame_good;
   assign status.acc_ready  = (acc_cnt_ff >= ACC_CNT_W'(8));
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign out_byte   = out_byte_ff;
   assign byte_index = byte_index_ff;
   assign last       = last_ff;

endmodule

// File: rtl/ibus_frame_to_sbus_converter_unit.sv
// top level of the ibus frame to sbus converter
//
// Takes received serial bytes, one word per handshake, each flagged when it
// follows a silent line gap. A gap word of 0x20 opens a 32-byte ibus frame;
// any other gap word drops a frame in progress. A frame is kept only when
// byte 1 is 0x40 and the checksum (0xFFFF minus bytes 0 to 29) matches bytes
// 30 and 31; bad frames vanish without output. For a good frame the 14
// channels are clamped to clamp_low..clamp_high, reduced by pwm_min, scaled by
// scale_ratio (16 fraction bits, rounded half up), offset by sbus_min and
// saturated to 11 bits, then packed lsb first into 23 sbus words (channels 14
// and 15 zero, word 22 zero and flagged last). Every received byte is taken
// while the sequencer waits in its receive state. After the last byte of a good
// frame, req_chan.ready stays low while the frame is converted: each of the 14
// used channels passes in turn through the frame ram's single read port, clamp,
// multiplier and round stages, the two unused channels skip the reads and pack
// as zero, each packed word is emitted as soon as eight bits are gathered, and a
// zero tail word ends the frame; a stalled output holds the sequencer. One
// output word register decouples the sink.
// Configuration writes take effect the cycle after csr_wr_en and should be
// made only while no frame is being converted.
module ibus_frame_to_sbus_converter_unit (
   input  logic                              clock,
   input  logic                              reset,
   ibsb_req_if.sink                          req_chan,
   ibsb_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [ibsb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ibsb_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import ibsb_pkg::*;

   ibsb_cfg_type    cfg;
   ibsb_cmd_type    cmd;
   ibsb_status_type status;

   // register file, reset to the stock clamp and scale values
   ibsb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .index   (csr_index),
      .wr_data (csr_wr_data),
      .cfg     (cfg)
   );

   // sequencer: owns the input handshake and the channel counter
   ibsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // frame ram, checksum, channel math, bit packer and output register
   ibsb_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .rx_byte    (req_chan.rx_byte),
      .after_gap  (req_chan.after_gap),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .out_byte   (rsp_chan.out_byte),
      .byte_index (rsp_chan.byte_index),
      .last       (rsp_chan.last)
   );

endmodule

// File: test/ibsb_sbus_model.sv
`timescale 1ns / 1ps
// class that predicts the sbus words of received ibus frames and checks the dut's words
package ibsb_tb_pkg;
   import ibsb_pkg::*;

   typedef struct {
      logic [7:0]       data;
      logic [IDX_W-1:0] idx;
      logic             last;
   } sbus_word_type;

   class ibus_to_sbus_model;
      ibsb_cfg_type  settings;
      logic [7:0]    frame_buf [FRAME_BYTES];
      int unsigned   taken;
      bit            collecting;
      logic [15:0]   csum;
      sbus_word_type sbus_words_due [$];
      int unsigned   errors;

      function new();
         settings   = {CLAMP_LOW_RST, CLAMP_HIGH_RST, PWM_MIN_RST, SBUS_MIN_RST,
                       SCALE_RATIO_RST};
         taken      = 0;
         collecting = 0;
         csum       = SUM_INIT;
         errors     = 0;
      endfunction

      function void write_reg(ibsb_reg_type r, logic [CSR_DATA_W-1:0] v);
         case (r)
            REG_CLAMP_LOW:   settings.clamp_low   = v[11:0];
            REG_CLAMP_HIGH:  settings.clamp_high  = v[11:0];
            REG_PWM_MIN:     settings.pwm_min     = v[11:0];
            REG_SBUS_MIN:    settings.sbus_min    = v[10:0];
            REG_SCALE_RATIO: settings.scale_ratio = v[17:0];
            default: ;
         endcase
      endfunction

      // clamp, offset, scale with rounding, add sbus offset, saturate
      function logic [CHAN_BITS-1:0] sbus_channel_of(logic [15:0] p);
         int unsigned     q;
         longint unsigned d;
         longint unsigned s;
         q = p;
         if (q < settings.clamp_low) q = settings.clamp_low;
         if (q > settings.clamp_high) q = settings.clamp_high;
         d = (q >= settings.pwm_min) ? q - settings.pwm_min : 0;
         s = (d * settings.scale_ratio + 64'd32768) >> 16;
         s = s + settings.sbus_min;
         if (s > 2047) s = 2047;
         return s[CHAN_BITS-1:0];
      endfunction

      function void note_word(logic [7:0] b, logic gap);
         logic [8*SBUS_BYTES-1:0] stream;
         logic [15:0]             pulse;
         if (gap) begin
            collecting = 0;
            taken      = 0;
            if (b == START_BYTE) begin
               collecting = 1;
               csum       = SUM_INIT;
            end
         end
         if (!collecting) return;
         frame_buf[taken] = b;
         taken++;
         if (taken < FRAME_BYTES - 1) csum = csum - 16'(b);
         if (taken < FRAME_BYTES) return;
         collecting = 0;
         taken      = 0;
         if (frame_buf[CMD_POS] != CMD_BYTE ||
             csum != {frame_buf[LAST_POS], frame_buf[SUM_LO_POS]}) return;
         // channels at and above CHANNELS and the tail byte stay zero
         stream = '0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            pulse = {frame_buf[3 + 2*ch], frame_buf[2 + 2*ch]};
            stream[ch*CHAN_BITS +: CHAN_BITS] = sbus_channel_of(pulse);
         end
         for (int k = 0; k < SBUS_BYTES; k++)
            sbus_words_due.push_back('{stream[8*k +: 8], IDX_W'(k), k == SBUS_BYTES - 1});
      endfunction

      function void check_word(logic [7:0] d, logic [IDX_W-1:0] idx, logic last);
         sbus_word_type want;
         if (sbus_words_due.size() == 0) begin
            $display("%0t: sbus word data %02h index %0d arrived with none expected",
                     $time, d, idx);
            errors++;
            return;
         end
         want = sbus_words_due.pop_front();
         if (d !== want.data) begin
            $display("%0t: out_byte mismatch at index %0d: expected %02h, got %02h",
                     $time, want.idx, want.data, d);
            errors++;
         end
         if (idx !== want.idx) begin
            $display("%0t: byte_index mismatch: expected %0d, got %0d",
                     $time, want.idx, idx);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch at index %0d: expected %0b, got %0b",
                     $time, want.idx, want.last, last);
            errors++;
         end
      endfunction

      function int unsigned words_due();
         return sbus_words_due.size();
      endfunction
   endclass

endpackage

// File: test/tb_top.sv
`timescale 1ns / 1ps
// testbench top that drives ibus frames through the converter and checks the sbus words
module tb_top;
   import ibsb_pkg::*;
   import ibsb_tb_pkg::*;

   // the worst run stays well under this limit, so it leaves a wide margin
   localparam int unsigned CYCLE_LIMIT = 400000;
   // long enough to cover the conversion of a good frame once the last byte is in
   localparam int unsigned SETTLE_CYCLES = 150;
   // each phase ends after the first burst of bytes
   localparam int unsigned PHASE_BYTES = 1;
   localparam int unsigned PHASES = 5;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   ibsb_req_if req_chan ();
   ibsb_rsp_if rsp_chan ();

   ibus_to_sbus_model conv_model = new();

   // channel pulses of the next frame to send
   logic [15:0] pulse_set [CHANNELS];
   // no idle cycles on a side while its rush flag is set
   bit          feed_rush;
   bit          drain_rush;
   int unsigned bytes_fed;
   int unsigned cycles = 0;

   ibus_frame_to_sbus_converter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("** ibus_frame_to_sbus_converter_unit: FAILED **");
         $finish;
      end
   end

   function automatic int unsigned idle_draw(bit rush);
      return rush ? 0 : $urandom_range(0, 18);
   endfunction

   // one received byte; entered and left at a falling edge, valid left high
   task automatic send_word(logic [7:0] b, logic gap);
      int unsigned n;
      n = idle_draw(feed_rush);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.rx_byte   <= b;
      req_chan.after_gap <= gap;
      do @(posedge clock); while (!req_chan.ready);
      conv_model.note_word(b, gap);
      bytes_fed++;
      @(negedge clock);
   endtask

   // builds an ibus frame from pulse_set and sends its first upto bytes
   task automatic send_frame(logic [7:0] cmd, logic [15:0] sum_flip, int unsigned upto);
      logic [7:0]  fr [FRAME_BYTES];
      logic [15:0] sum;
      fr[0] = START_BYTE;
      fr[1] = cmd;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         fr[2 + 2*ch] = pulse_set[ch][7:0];
         fr[3 + 2*ch] = pulse_set[ch][15:8];
      end
      sum = SUM_INIT;
      for (int k = 0; k < FRAME_BYTES - 2; k++) sum = sum - 16'(fr[k]);
      // a nonzero flip breaks the checksum
      sum = sum ^ sum_flip;
      fr[FRAME_BYTES - 2] = sum[7:0];
      fr[FRAME_BYTES - 1] = sum[15:8];
      feed_rush = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < upto; k++) send_word(fr[k], k == 0);
   endtask

   // mix of full range, 12-bit range, values around the set limits and the extremes
   task automatic random_pulses();
      int unsigned near;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         case ($urandom_range(0, 3))
            0: pulse_set[ch] = 16'($urandom_range(0, 65535));
            1: pulse_set[ch] = 16'($urandom_range(0, 4095));
            2: begin
               case ($urandom_range(0, 2))
                  0: near = conv_model.settings.clamp_low;
                  1: near = conv_model.settings.clamp_high;
                  default: near = conv_model.settings.pwm_min;
               endcase
               pulse_set[ch] = 16'(near + $urandom_range(0, 8)) - 16'd4;
            end
            default: pulse_set[ch] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         endcase
      end
   endtask

   task automatic put_reg(ibsb_reg_type r, logic [CSR_DATA_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_index   <= r;
      csr_wr_data <= v;
      conv_model.write_reg(r, v);
      @(negedge clock);
   endtask

   // writes all five registers back to back, only while the block is idle
   task automatic load_settings(ibsb_cfg_type c);
      put_reg(REG_CLAMP_LOW, CSR_DATA_W'(c.clamp_low));
      put_reg(REG_CLAMP_HIGH, CSR_DATA_W'(c.clamp_high));
      put_reg(REG_PWM_MIN, CSR_DATA_W'(c.pwm_min));
      put_reg(REG_SBUS_MIN, CSR_DATA_W'(c.sbus_min));
      put_reg(REG_SCALE_RATIO, CSR_DATA_W'(c.scale_ratio));
      csr_wr_en <= 1'b0;
   endtask

   // stop feeding, drain every expected word, then let a bad frame's check finish
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (conv_model.words_due() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sbus word sink with random stalls
   initial begin : drain
      int unsigned n;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         n = idle_draw(drain_rush);
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         conv_model.check_word(rsp_chan.out_byte, rsp_chan.byte_index, rsp_chan.last);
         if ($urandom_range(0, 29) == 0) drain_rush = !drain_rush;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      ibsb_cfg_type c;
      int unsigned  start;
      logic [7:0]   b;
      req_chan.valid     = 1'b0;
      req_chan.rx_byte   = 8'h00;
      req_chan.after_gap = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      bytes_fed          = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, reset settings
      // stray bytes while idle, a gap byte that is not a start byte among them
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h55, 1'b1);
      // pulses at the extremes and on both sides of the clamp and offset limits
      pulse_set = '{16'h0000, 16'hFFFF, 16'd884, 16'd885, 16'd886, 16'd987, 16'd988,
                    16'd989, 16'd2159, 16'd2160, 16'd2161, 16'h8000, 16'h2020, 16'h0FFF};
      send_frame(CMD_BYTE, 16'h0000, FRAME_BYTES);
      // bad command byte, bad checksum in the low and in the high byte
      send_frame(8'h41, 16'h0000, FRAME_BYTES);
      send_frame(CMD_BYTE, 16'h0001, FRAME_BYTES);
      send_frame(CMD_BYTE, 16'h8000, FRAME_BYTES);
      // frame cut by a gap byte that is not a start byte, then a stray byte
      send_frame(CMD_BYTE, 16'h0000, 17);
      send_word(8'h21, 1'b1);
      send_word(8'hAA, 1'b0);
      // frame one byte short, restarted by a new start byte
      send_frame(CMD_BYTE, 16'h0000, FRAME_BYTES - 1);
      random_pulses();
      send_frame(CMD_BYTE, 16'h0000, FRAME_BYTES);
      settle();

      // random part, one setting per phase
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            // widest window, no offsets, largest ratio: mostly saturated
            0: c = {12'd0, 12'd4095, 12'd0, 11'd0, 18'h3FFFF};
            // crossed clamp limits, zero ratio, largest sbus offset
            1: c = {12'd4095, 12'd0, 12'd4095, 11'd2047, 18'd0};
            2: c = {CLAMP_LOW_RST, CLAMP_HIGH_RST, PWM_MIN_RST, SBUS_MIN_RST, SCALE_RATIO_RST};
            default: begin
               c.clamp_low   = 12'($urandom_range(0, 4095));
               c.clamp_high  = 12'($urandom_range(0, 4095));
               c.pwm_min     = 12'($urandom_range(0, 4095));
               c.sbus_min    = 11'($urandom_range(0, 2047));
               c.scale_ratio = $urandom_range(0, 1) ? 18'($urandom_range(0, 262143))
                                                    : 18'($urandom_range(20000, 140000));
            end
         endcase
         load_settings(c);
         start = bytes_fed;
         while (bytes_fed - start < PHASE_BYTES) begin
            random_pulses();
            case ($urandom_range(0, 9))
               7: begin
                  // bad frame: wrong command byte or broken checksum
                  if ($urandom_range(0, 1)) begin
                     b = 8'($urandom_range(0, 255));
                     if (b == CMD_BYTE) b = ~b;
                     send_frame(b, 16'h0000, FRAME_BYTES);
                  end else begin
                     send_frame(CMD_BYTE, 16'($urandom_range(1, 65535)), FRAME_BYTES);
                  end
               end
               8: begin
                  // cut frame, sometimes followed by an abort gap byte
                  send_frame(CMD_BYTE, 16'h0000, $urandom_range(1, FRAME_BYTES - 1));
                  if ($urandom_range(0, 1)) begin
                     b = 8'($urandom_range(0, 255));
                     if (b == START_BYTE) b = ~b;
                     send_word(b, 1'b1);
                  end
               end
               9: begin
                  // line noise with random gap flags
                  repeat ($urandom_range(1, 4))
                     send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
               end
               default: send_frame(CMD_BYTE, 16'h0000, FRAME_BYTES);
            endcase
         end
         settle();
      end

      if (conv_model.errors == 0)
         $display("** ibus_frame_to_sbus_converter_unit: PASSED **");
      else
         $display("** ibus_frame_to_sbus_converter_unit: FAILED **");
      $finish;
   end

endmodule
